// ----- sv/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int unsigned PAGES_DEF  = 4096;
  localparam int unsigned ORDERS_DEF = 11;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned PFN_W      = 12;
  localparam int unsigned STAT_W     = 3;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_ORDER   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_IGNORED = 3'd4,
    ST_RANGE   = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_A_LOOP,
    S_A_SPLIT,
    S_A_SPLIT2,
    S_A_FIN,
    S_P_RD,
    S_P_NX,
    S_P_FIX,
    S_U_ST,
    S_U_LINK,
    S_F_CHK,
    S_F_MERGE,
    S_F_BUD,
    S_N_PV,
    S_N_PVW,
    S_N_NX,
    S_N_NXW,
    S_N_B,
    S_F_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             action;
    logic [CNT_W-1:0] page_count;
    logic [PFN_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [PFN_W-1:0] pfn;
  } res_t;

  // ceiling log2 of a page count, 0 for counts of 0 and 1
  function automatic logic [3:0] order_of(input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] m;
    logic [3:0]       o;
    m = count - CNT_W'(1);
    o = 4'd0;
    if (count > CNT_W'(1)) begin
      for (int i = 0; i < CNT_W; i++) begin
        if (m[i]) o = 4'(i + 1);
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: list heads/tails/counts and read-modify-write of the page table.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl #(
  parameter int unsigned PAGES  = bpa_pkg::PAGES_DEF,
  parameter int unsigned ORDERS = bpa_pkg::ORDERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire bpa_pkg::req_t               req_i,
  input  wire logic [bpa_pkg::CNT_W-1:0]   page_limit_i,
  output logic                             ready_o,
  output bpa_pkg::res_t                    res_o,
  input  wire logic                        res_ready_i
);

  import bpa_pkg::*;

  localparam int unsigned PW = $clog2(PAGES);
  localparam int unsigned LW = PW + 1;
  localparam int unsigned OW = $clog2(ORDERS);
  localparam int unsigned WW = 1 + OW + 2 * LW;
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  // page word: free, order, next link, prev link (from the top bit down)
  function automatic logic f_free(input logic [WW-1:0] w);
    return w[WW-1];
  endfunction
  function automatic logic [OW-1:0] f_ord(input logic [WW-1:0] w);
    return w[WW-2 -: OW];
  endfunction
  function automatic logic [LW-1:0] f_next(input logic [WW-1:0] w);
    return w[2*LW-1 -: LW];
  endfunction
  function automatic logic [LW-1:0] f_prev(input logic [WW-1:0] w);
    return w[LW-1:0];
  endfunction
  function automatic logic [WW-1:0] mk(input logic fr, input logic [OW-1:0] o,
                                       input logic [LW-1:0] nx,
                                       input logic [LW-1:0] pv);
    return {fr, o, nx, pv};
  endfunction
  function automatic logic link_ok(input logic [LW-1:0] l);
    return l < NIL;
  endfunction

  state_e        state_q, state_d, ret_q, ret_d;
  logic [OW-1:0] ord_q, ord_d, req_q, req_d;
  logic [PW-1:0] pg_q, pg_d, up_q, up_d, tgt_q, tgt_d, bd_q, bd_d, clr_q, clr_d;
  logic [WW-1:0] wd_q, wd_d;
  status_e       st_q, st_d;
  logic [PFN_W-1:0] rs_q, rs_d;

  logic [LW-1:0] head_q [ORDERS];
  logic [LW-1:0] tail_q [ORDERS];
  logic [LW-1:0] cnt_q  [ORDERS];

  logic          hd_we, tl_we, cnt_inc, cnt_dec;
  logic [LW-1:0] hd_val, tl_val, head_cur, tail_cur, cnt_cur;

  logic          we;
  logic [PW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;

  // a read of the page written in the same cycle returns the new word
  logic          fwd_hit_q, fwd_hit_d;
  logic [WW-1:0] fwd_data_q, rword;

  logic [3:0]    ordn;
  logic [31:0]   bsum, usum;
  logic [OW-1:0] lo;

  assign head_cur  = head_q[ord_q];
  assign tail_cur  = tail_q[ord_q];
  assign cnt_cur   = cnt_q[ord_q];
  assign fwd_hit_d = we && (waddr == raddr);
  assign rword     = fwd_hit_q ? fwd_data_q : rdata;

  bpa_ram #(
    .WIDTH(WW),
    .DEPTH(PAGES)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ord_d   = ord_q;
    req_d   = req_q;
    pg_d    = pg_q;
    up_d    = up_q;
    tgt_d   = tgt_q;
    bd_d    = bd_q;
    clr_d   = clr_q;
    wd_d    = wd_q;
    st_d    = st_q;
    rs_d    = rs_q;
    we      = 1'b0;
    waddr   = pg_q;
    wdata   = '0;
    raddr   = pg_q;
    hd_we   = 1'b0;
    hd_val  = NIL;
    tl_we   = 1'b0;
    tl_val  = NIL;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    ready_o = 1'b0;
    res_o   = '{valid: 1'b0, status: st_q, pfn: rs_q};
    ordn    = order_of(req_i.page_count);
    lo      = ord_q - OW'(1);
    bsum    = 32'(pg_q) ^ (32'd1 << ord_q);
    usum    = 32'(pg_q) + (32'd1 << lo);
    if (usum >= PAGES) usum = usum - PAGES;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + PW'(1);
        if (clr_q == PW'(PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          rs_d = '0;
          if (req_i.action == ACT_ALLOC) begin
            if (req_i.page_count == '0) begin
              st_d = ST_ZERO; state_d = S_DONE;
            end else if (32'(ordn) >= ORDERS) begin
              st_d = ST_ORDER; state_d = S_DONE;
            end else begin
              req_d   = OW'(ordn);
              ord_d   = OW'(ordn);
              state_d = S_SEARCH;
            end
          end else begin
            if (req_i.page_number == '0 || req_i.page_count == '0) begin
              st_d = ST_IGNORED; state_d = S_DONE;
            end else if (32'(req_i.page_number) >= 32'(page_limit_i) ||
                         32'(req_i.page_number) >= PAGES) begin
              st_d = ST_RANGE; state_d = S_DONE;
            end else if (32'(ordn) >= ORDERS) begin
              st_d = ST_ORDER; state_d = S_DONE;
            end else begin
              pg_d    = PW'(req_i.page_number);
              ord_d   = OW'(ordn);
              raddr   = PW'(req_i.page_number);
              state_d = S_F_CHK;
            end
          end
        end
      end
      S_SEARCH: begin
        if (cnt_cur != '0) begin
          state_d = S_A_LOOP;
        end else if (32'(ord_q) == ORDERS - 1) begin
          st_d = ST_EMPTY; state_d = S_DONE;
        end else begin
          ord_d = ord_q + OW'(1);
        end
      end
      S_A_LOOP: begin
        ret_d   = (ord_q > req_q) ? S_A_SPLIT : S_A_FIN;
        state_d = S_P_RD;
      end
      S_A_SPLIT: begin
        tgt_d   = pg_q;
        up_d    = PW'(usum);
        ord_d   = lo;
        ret_d   = S_A_SPLIT2;
        state_d = S_U_ST;
      end
      S_A_SPLIT2: begin
        tgt_d   = up_q;
        ret_d   = S_A_LOOP;
        state_d = S_U_ST;
      end
      S_A_FIN: begin
        st_d    = ST_OK;
        rs_d    = PFN_W'(pg_q);
        state_d = S_DONE;
      end
      // pop the list head
      S_P_RD: begin
        if (!link_ok(head_cur)) begin
          st_d = ST_EMPTY; state_d = S_DONE;
        end else begin
          pg_d    = head_cur[PW-1:0];
          raddr   = head_cur[PW-1:0];
          state_d = S_P_NX;
        end
      end
      S_P_NX: begin
        hd_we   = 1'b1;
        hd_val  = f_next(rword);
        cnt_dec = 1'b1;
        we      = 1'b1;
        wdata   = mk(1'b0, f_ord(rword), NIL, f_prev(rword));
        if (link_ok(f_next(rword))) begin
          raddr   = PW'(f_next(rword));
          bd_d    = PW'(f_next(rword));
          state_d = S_P_FIX;
        end else begin
          tl_we   = 1'b1;
          state_d = ret_q;
        end
      end
      S_P_FIX: begin
        we      = 1'b1;
        waddr   = bd_q;
        wdata   = mk(f_free(rword), f_ord(rword), f_next(rword), NIL);
        state_d = ret_q;
      end
      // append tgt_q to the list tail
      S_U_ST: begin
        we      = 1'b1;
        waddr   = tgt_q;
        wdata   = mk(1'b1, ord_q, NIL, tail_cur);
        tl_we   = 1'b1;
        tl_val  = LW'(tgt_q);
        cnt_inc = 1'b1;
        if (link_ok(tail_cur)) begin
          raddr   = tail_cur[PW-1:0];
          bd_d    = tail_cur[PW-1:0];
          state_d = S_U_LINK;
        end else begin
          hd_we   = 1'b1;
          hd_val  = LW'(tgt_q);
          state_d = ret_q;
        end
      end
      S_U_LINK: begin
        we      = 1'b1;
        waddr   = bd_q;
        wdata   = mk(f_free(rword), f_ord(rword), LW'(tgt_q), f_prev(rword));
        state_d = ret_q;
      end
      S_F_CHK: begin
        if (f_free(rword)) begin
          st_d = ST_IGNORED; state_d = S_DONE;
        end else begin
          state_d = S_F_MERGE;
        end
      end
      S_F_MERGE: begin
        if (32'(ord_q) < ORDERS - 1 && bsum < 32'(page_limit_i) && bsum < PAGES) begin
          bd_d    = PW'(bsum);
          raddr   = PW'(bsum);
          state_d = S_F_BUD;
        end else begin
          tgt_d   = pg_q;
          ret_d   = S_F_FIN;
          state_d = S_U_ST;
        end
      end
      S_F_BUD: begin
        wd_d = rword;
        if (!f_free(rword) || f_ord(rword) != ord_q) begin
          tgt_d   = pg_q;
          ret_d   = S_F_FIN;
          state_d = S_U_ST;
        end else begin
          state_d = S_N_PV;
        end
      end
      // unlink the buddy held in wd_q / bd_q
      S_N_PV: begin
        if (link_ok(f_prev(wd_q))) begin
          raddr   = PW'(f_prev(wd_q));
          state_d = S_N_PVW;
        end else begin
          hd_we   = 1'b1;
          hd_val  = f_next(wd_q);
          state_d = S_N_NX;
        end
      end
      S_N_PVW: begin
        we      = 1'b1;
        waddr   = PW'(f_prev(wd_q));
        wdata   = mk(f_free(rword), f_ord(rword), f_next(wd_q), f_prev(rword));
        state_d = S_N_NX;
      end
      S_N_NX: begin
        if (link_ok(f_next(wd_q))) begin
          raddr   = PW'(f_next(wd_q));
          state_d = S_N_NXW;
        end else begin
          tl_we   = 1'b1;
          tl_val  = f_prev(wd_q);
          state_d = S_N_B;
        end
      end
      S_N_NXW: begin
        we      = 1'b1;
        waddr   = PW'(f_next(wd_q));
        wdata   = mk(f_free(rword), f_ord(rword), f_next(rword), f_prev(wd_q));
        state_d = S_N_B;
      end
      S_N_B: begin
        we      = 1'b1;
        waddr   = bd_q;
        wdata   = mk(1'b0, f_ord(wd_q), NIL, NIL);
        cnt_dec = 1'b1;
        if (bd_q < pg_q) pg_d = bd_q;
        ord_d   = ord_q + OW'(1);
        state_d = S_F_MERGE;
      end
      S_F_FIN: begin
        st_d    = ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ret_q     <= S_IDLE;
      clr_q     <= '0;
      fwd_hit_q <= 1'b0;
      for (int i = 0; i < ORDERS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      clr_q     <= clr_d;
      fwd_hit_q <= fwd_hit_d;
      if (hd_we) head_q[ord_q] <= hd_val;
      if (tl_we) tail_q[ord_q] <= tl_val;
      if (cnt_inc) begin
        cnt_q[ord_q] <= cnt_cur + LW'(1);
      end else if (cnt_dec && cnt_cur != '0) begin
        cnt_q[ord_q] <= cnt_cur - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q      <= ord_d;
    req_q      <= req_d;
    pg_q       <= pg_d;
    up_q       <= up_d;
    tgt_q      <= tgt_d;
    bd_q       <= bd_d;
    wd_q       <= wd_d;
    st_q       <= st_d;
    rs_q       <= rs_d;
    fwd_data_q <= wdata;
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("item started while sequencer busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != ST_OK) |-> res_o.pfn == '0)
    else $error("failed request returned a page");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && clr_q == PW'(PAGES - 1)) |=> state_q == S_IDLE)
    else $error("clearing pass did not finish");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_U_ST |-> (we && wdata[WW-1]))
    else $error("list append did not mark page free");

endmodule

`default_nettype wire

// ----- sv/buddy_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator over page frame numbers with per-order FIFO lists.
// ----------------------------------------------------------------------------
// Usage: one request per s_axis transaction (tuser: allocate or free,
// tdata: count and page), one result per request on m_axis (status and the
// allocated page). Requests are taken one at a time; one rejected at
// decode goes straight to its result. Every split or merge level
// performs several read-modify-writes on the page table RAM (one read and
// one write port, registered read, same-cycle accesses to one page
// forwarded), plus a search of the lists from the requested order up
// for an allocate.
// The result sits in an output register, so a stalled receiver holds it
// while the sequencer goes back to idle; the next result waits until the
// register is taken. After reset all PAGES page words (4096 by default) are
// cleared with s_axis_tready low; cfg writes are taken at any
// time and should only be issued while idle. Reset leaves every list empty:
// software seeds the pool by freeing pages.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_unit #(
  parameter int unsigned PAGES  = bpa_pkg::PAGES_DEF,
  parameter int unsigned ORDERS = bpa_pkg::ORDERS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // page_count[12:0], page_number[24:13]
  input  wire logic        s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // status[2:0], page_number_res[14:3]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [bpa_pkg::CNT_W-1:0] cfg_data_i  // number of managed pages
);

  import bpa_pkg::*;

  logic [CNT_W-1:0] total_q, total_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      out_data_q, out_data_d;
  logic             ctrl_ready, res_ready, start;
  req_t             req;
  res_t             res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ctrl_ready;
  assign start         = s_axis_tvalid && ctrl_ready;
  assign req           = '{action: s_axis_tuser, page_count: s_axis_tdata[12:0],
                           page_number: s_axis_tdata[24:13]};
  assign res_ready     = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  bpa_ctrl #(
    .PAGES (PAGES),
    .ORDERS(ORDERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .page_limit_i(total_q),
    .ready_o     (ctrl_ready),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_comb begin
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cfg_valid_i) total_d = cfg_data_i;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, res.pfn, res.status};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
